// ===== sv/brk4_pkg.sv =====
package brk4_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int CONC_BITS = 31;
   localparam int TIME_BITS = 63;
   localparam int NORM_BITS = 32;
   localparam int OPND_BITS = WORD_BITS + 1;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int DIV6_SHIFT = 34;
   localparam int IDX_BITS = 5;

   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [OPND_BITS-1:0] ONE_VAL = OPND_BITS'(1) << FRAC_BITS;
   // ceil(2^33/3): (n * RCP3) >> 34 gives n/6 for any n below 2^33
   localparam logic signed [OPND_BITS-1:0] RCP3 = 33'h0AAAAAAAB;

   localparam logic [CONC_BITS-1:0] A_RESET = 31'd16777216;
   localparam logic [CONC_BITS-1:0] B_RESET = 31'd50331648;
   localparam logic [CONC_BITS-1:0] DT_RESET = 31'd167772;

   localparam logic [1:0] REG_A = 2'd0;
   localparam logic [1:0] REG_B = 2'd1;
   localparam logic [1:0] REG_DT = 2'd2;

   localparam logic [IDX_BITS-1:0] PRE_LAST = 5'd3;
   localparam logic [IDX_BITS-1:0] SLOPE_LAST = 5'd11;
   localparam logic [IDX_BITS-1:0] ACC_LAST = 5'd3;
   localparam logic [IDX_BITS-1:0] NEXT_LAST = 5'd5;
   localparam logic [IDX_BITS-1:0] FIN_LAST = 5'd6;
   localparam logic [IDX_BITS-1:0] NORM_LAST = 5'd3;
   localparam logic [IDX_BITS-1:0] SQRT_LAST = 5'd31;
   localparam logic [1:0] LAST_STAGE = 2'd3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [OPND_BITS-1:0] opnd_type;

   typedef struct packed {
      logic func;
      logic [CONC_BITS-1:0] load_x;
      logic [CONC_BITS-1:0] load_y;
   } req_type;

   typedef struct packed {
      logic [CONC_BITS-1:0] x_out;
      logic [CONC_BITS-1:0] y_out;
      logic [TIME_BITS-1:0] time_out;
      logic [NORM_BITS-1:0] norm_out;
      logic saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRE, ST_SLOPE, ST_ACC, ST_NEXT, ST_FIN, ST_NORM, ST_SQRT, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_MUL, OP_MRND, OP_MDIV6, OP_ADD, OP_SUB, OP_TIME, OP_SQSET, OP_SQACC
   } op_type;

   typedef enum logic [4:0] {
      SRC_ZERO, SRC_ONE, SRC_A, SRC_B, SRC_DT, SRC_HALF, SRC_DT3, SRC_RCP3, SRC_SIX,
      SRC_XC, SRC_YC, SRC_XS, SRC_YS, SRC_DX, SRC_DY, SRC_SX, SRC_SY, SRC_T1, SRC_T2
   } src_type;

   typedef enum logic [3:0] {
      DST_T1, DST_T2, DST_XS, DST_YS, DST_DX, DST_DY, DST_SX, DST_SY, DST_SIX,
      DST_XC, DST_YC
   } dst_type;

   typedef struct packed {
      op_type op;
      src_type sa;
      src_type sb;
      dst_type dst;
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic load;
      logic clear;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   function automatic uop_type mk(op_type op, src_type sa, src_type sb, dst_type dst);
      uop_type u;
      u.op = op;
      u.sa = sa;
      u.sb = sb;
      u.dst = dst;
      return u;
   endfunction

   localparam uop_type UOP_NOP = '{OP_NOP, SRC_ZERO, SRC_ZERO, DST_T1};

   // dt/6, then first stage state
   function automatic uop_type pre_uop(logic [3:0] idx);
      case (idx)
         4'd0: return mk(OP_MUL, SRC_DT3, SRC_RCP3, DST_T1);
         4'd1: return mk(OP_MDIV6, SRC_ZERO, SRC_ZERO, DST_SIX);
         4'd2: return mk(OP_ADD, SRC_XC, SRC_ZERO, DST_XS);
         4'd3: return mk(OP_ADD, SRC_YC, SRC_ZERO, DST_YS);
         default: return UOP_NOP;
      endcase
   endfunction

   // slopes at (XS, YS)
   function automatic uop_type slope_uop(logic [3:0] idx);
      case (idx)
         4'd0: return mk(OP_MUL, SRC_XS, SRC_XS, DST_T1);
         4'd1: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd2: return mk(OP_MUL, SRC_T1, SRC_YS, DST_T1);
         4'd3: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T2);
         4'd4: return mk(OP_ADD, SRC_B, SRC_ONE, DST_T1);
         4'd5: return mk(OP_MUL, SRC_T1, SRC_XS, DST_T1);
         4'd6: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd7: return mk(OP_SUB, SRC_A, SRC_T1, DST_T1);
         4'd8: return mk(OP_ADD, SRC_T1, SRC_T2, DST_DX);
         4'd9: return mk(OP_MUL, SRC_B, SRC_XS, DST_T1);
         4'd10: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd11: return mk(OP_SUB, SRC_T1, SRC_T2, DST_DY);
         default: return UOP_NOP;
      endcase
   endfunction

   // running weighted sum d1 + 2 d2 + 2 d3 + d4
   function automatic uop_type acc_uop(logic [1:0] stage, logic [3:0] idx);
      if (stage == 2'd0) begin
         case (idx)
            4'd0: return mk(OP_ADD, SRC_DX, SRC_ZERO, DST_SX);
            4'd1: return mk(OP_ADD, SRC_DY, SRC_ZERO, DST_SY);
            default: return UOP_NOP;
         endcase
      end else if (stage == LAST_STAGE) begin
         case (idx)
            4'd0: return mk(OP_ADD, SRC_SX, SRC_DX, DST_SX);
            4'd1: return mk(OP_ADD, SRC_SY, SRC_DY, DST_SY);
            default: return UOP_NOP;
         endcase
      end
      case (idx)
         4'd0: return mk(OP_ADD, SRC_DX, SRC_DX, DST_T1);
         4'd1: return mk(OP_ADD, SRC_SX, SRC_T1, DST_SX);
         4'd2: return mk(OP_ADD, SRC_DY, SRC_DY, DST_T1);
         4'd3: return mk(OP_ADD, SRC_SY, SRC_T1, DST_SY);
         default: return UOP_NOP;
      endcase
   endfunction

   // next stage state: half step twice, then full step
   function automatic uop_type next_uop(logic [1:0] stage, logic [3:0] idx);
      src_type f;
      f = (stage == 2'd2) ? SRC_DT : SRC_HALF;
      case (idx)
         4'd0: return mk(OP_MUL, f, SRC_DX, DST_T1);
         4'd1: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd2: return mk(OP_ADD, SRC_XC, SRC_T1, DST_XS);
         4'd3: return mk(OP_MUL, f, SRC_DY, DST_T1);
         4'd4: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd5: return mk(OP_ADD, SRC_YC, SRC_T1, DST_YS);
         default: return UOP_NOP;
      endcase
   endfunction

   function automatic uop_type fin_uop(logic [3:0] idx);
      case (idx)
         4'd0: return mk(OP_MUL, SRC_SIX, SRC_SX, DST_T1);
         4'd1: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd2: return mk(OP_ADD, SRC_XC, SRC_T1, DST_XC);
         4'd3: return mk(OP_MUL, SRC_SIX, SRC_SY, DST_T1);
         4'd4: return mk(OP_MRND, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd5: return mk(OP_ADD, SRC_YC, SRC_T1, DST_YC);
         4'd6: return mk(OP_TIME, SRC_ZERO, SRC_ZERO, DST_T1);
         default: return UOP_NOP;
      endcase
   endfunction

   function automatic uop_type norm_uop(logic [3:0] idx);
      case (idx)
         4'd0: return mk(OP_MUL, SRC_XC, SRC_XC, DST_T1);
         4'd1: return mk(OP_SQSET, SRC_ZERO, SRC_ZERO, DST_T1);
         4'd2: return mk(OP_MUL, SRC_YC, SRC_YC, DST_T1);
         4'd3: return mk(OP_SQACC, SRC_ZERO, SRC_ZERO, DST_T1);
         default: return UOP_NOP;
      endcase
   endfunction

endpackage

// ===== sv/brusselator_rk4_stepper_core.sv =====
// One request at a time: a new request is accepted only after the previous result has
// moved to the output register. Each RK4 stage runs 22 micro-operations (16 in the last)
// through the single shared multiplier and adder, plus a bit-pair square root for the norm.
// Reset (synchronous): concentrations and time clear to zero, coefficients return
// to A = 1.0, B = 3.0, dt = 167772 raw; no result is pending.
module brusselator_rk4_stepper_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  brk4_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output brk4_pkg::rsp_type rsp_payload,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [brk4_pkg::CONC_BITS-1:0] csr_wdata
);
   import brk4_pkg::*;

   cmd_type cmd;

   brk4_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_func(req_payload.func),
      .req_ready(req_ready),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .cmd(cmd)
   );

   brk4_dp u_dp (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_payload(req_payload),
      .cmd(cmd),
      .rsp_payload(rsp_payload)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before taken");

   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_payload.norm_out >= 32'(rsp_payload.x_out)
                            && rsp_payload.norm_out >= 32'(rsp_payload.y_out)))
      else $error("norm below a concentration");

endmodule

// ===== sv/brk4_ctrl.sv =====
module brk4_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_func,
   output logic req_ready,
   input  logic rsp_ready,
   output logic rsp_valid,
   output brk4_pkg::cmd_type cmd
);
   import brk4_pkg::*;

   state_type state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [1:0] stage_ff, stage_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff + 5'd1;
      stage_in = stage_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            stage_in = '0;
            if (req_valid) begin
               state_in = req_func ? ST_NORM : ST_PRE;
            end
         end
         ST_PRE: begin
            if (idx_ff == PRE_LAST) begin
               state_in = ST_SLOPE;
               idx_in = '0;
            end
         end
         ST_SLOPE: begin
            if (idx_ff == SLOPE_LAST) begin
               state_in = ST_ACC;
               idx_in = '0;
            end
         end
         ST_ACC: begin
            if (idx_ff == ACC_LAST) begin
               state_in = (stage_ff == LAST_STAGE) ? ST_FIN : ST_NEXT;
               idx_in = '0;
            end
         end
         ST_NEXT: begin
            if (idx_ff == NEXT_LAST) begin
               state_in = ST_SLOPE;
               idx_in = '0;
               stage_in = stage_ff + 2'd1;
            end
         end
         ST_FIN: begin
            if (idx_ff == FIN_LAST) begin
               state_in = ST_NORM;
               idx_in = '0;
            end
         end
         ST_NORM: begin
            if (idx_ff == NORM_LAST) begin
               state_in = ST_SQRT;
               idx_in = '0;
            end
         end
         ST_SQRT: begin
            if (idx_ff == SQRT_LAST) begin
               state_in = ST_DONE;
               idx_in = '0;
            end
         end
         ST_DONE: begin
            idx_in = '0;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in = '0;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.uop = UOP_NOP;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.clear = req_valid;
            cmd.load = req_valid && req_func;
         end
         ST_PRE: cmd.uop = pre_uop(idx_ff[3:0]);
         ST_SLOPE: cmd.uop = slope_uop(idx_ff[3:0]);
         ST_ACC: cmd.uop = acc_uop(stage_ff, idx_ff[3:0]);
         ST_NEXT: cmd.uop = next_uop(stage_ff, idx_ff[3:0]);
         ST_FIN: cmd.uop = fin_uop(idx_ff[3:0]);
         ST_NORM: cmd.uop = norm_uop(idx_ff[3:0]);
         ST_SQRT: cmd.sqrt_step = 1'b1;
         ST_DONE: cmd.out_load = out_free;
         default: cmd.uop = UOP_NOP;
      endcase
   end

   // hold the result until taken
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         stage_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         stage_ff <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/brk4_dp.sv =====
module brk4_dp (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [brk4_pkg::CONC_BITS-1:0] csr_wdata,
   input  brk4_pkg::req_type req_payload,
   input  brk4_pkg::cmd_type cmd,
   output brk4_pkg::rsp_type rsp_payload
);
   import brk4_pkg::*;

   logic [CONC_BITS-1:0] a_ff, b_ff, dt_ff;
   logic [CONC_BITS-1:0] x_ff, y_ff;
   logic [TIME_BITS-1:0] time_ff;
   word_type t1_ff, t2_ff, xs_ff, ys_ff, dx_ff, dy_ff, sx_ff, sy_ff, six_ff;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   logic [PROD_BITS-1:0] sum_ff, res_ff, bit_ff;
   logic sat_ff;
   rsp_type rsp_ff;

   opnd_type opa, opb;
   logic [WORD_BITS-1:0] half_val;
   logic [WORD_BITS-1:0] mag_a, mag_b;
   opnd_type abs_a, abs_b;
   logic [PROD_BITS:0] rnd_sum;
   logic [PROD_BITS-FRAC_BITS:0] rnd_mag;
   logic [PROD_BITS-FRAC_BITS:0] rnd_limit;
   logic signed [OPND_BITS:0] add_sum;
   word_type wb_in;
   logic wb_en, wb_sat;
   logic [PROD_BITS-1:0] time_sum;
   logic [PROD_BITS-1:0] trial;

   assign half_val = ({1'b0, dt_ff} + 32'd1) >> 1;

   always_comb begin
      case (cmd.uop.sa)
         SRC_ZERO: opa = '0;
         SRC_ONE: opa = ONE_VAL;
         SRC_A: opa = {2'b00, a_ff};
         SRC_B: opa = {2'b00, b_ff};
         SRC_DT: opa = {2'b00, dt_ff};
         SRC_HALF: opa = {1'b0, half_val};
         SRC_DT3: opa = {2'b00, dt_ff} + 33'd3;
         SRC_RCP3: opa = RCP3;
         SRC_SIX: opa = OPND_BITS'(six_ff);
         SRC_XC: opa = {2'b00, x_ff};
         SRC_YC: opa = {2'b00, y_ff};
         SRC_XS: opa = OPND_BITS'(xs_ff);
         SRC_YS: opa = OPND_BITS'(ys_ff);
         SRC_DX: opa = OPND_BITS'(dx_ff);
         SRC_DY: opa = OPND_BITS'(dy_ff);
         SRC_SX: opa = OPND_BITS'(sx_ff);
         SRC_SY: opa = OPND_BITS'(sy_ff);
         SRC_T1: opa = OPND_BITS'(t1_ff);
         SRC_T2: opa = OPND_BITS'(t2_ff);
         default: opa = '0;
      endcase
   end

   always_comb begin
      case (cmd.uop.sb)
         SRC_ZERO: opb = '0;
         SRC_ONE: opb = ONE_VAL;
         SRC_A: opb = {2'b00, a_ff};
         SRC_B: opb = {2'b00, b_ff};
         SRC_DT: opb = {2'b00, dt_ff};
         SRC_HALF: opb = {1'b0, half_val};
         SRC_DT3: opb = {2'b00, dt_ff} + 33'd3;
         SRC_RCP3: opb = RCP3;
         SRC_SIX: opb = OPND_BITS'(six_ff);
         SRC_XC: opb = {2'b00, x_ff};
         SRC_YC: opb = {2'b00, y_ff};
         SRC_XS: opb = OPND_BITS'(xs_ff);
         SRC_YS: opb = OPND_BITS'(ys_ff);
         SRC_DX: opb = OPND_BITS'(dx_ff);
         SRC_DY: opb = OPND_BITS'(dy_ff);
         SRC_SX: opb = OPND_BITS'(sx_ff);
         SRC_SY: opb = OPND_BITS'(sy_ff);
         SRC_T1: opb = OPND_BITS'(t1_ff);
         SRC_T2: opb = OPND_BITS'(t2_ff);
         default: opb = '0;
      endcase
   end

   // sign-magnitude multiply; rounding happens in the following op
   assign abs_a = opa[OPND_BITS-1] ? -opa : opa;
   assign abs_b = opb[OPND_BITS-1] ? -opb : opb;
   assign mag_a = abs_a[WORD_BITS-1:0];
   assign mag_b = abs_b[WORD_BITS-1:0];
   assign prod_in = PROD_BITS'(mag_a) * PROD_BITS'(mag_b);
   assign neg_in = opa[OPND_BITS-1] ^ opb[OPND_BITS-1];

   // round to nearest, ties away from zero
   assign rnd_sum = {1'b0, prod_ff} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1));
   assign rnd_mag = rnd_sum[PROD_BITS:FRAC_BITS];
   assign rnd_limit = neg_ff ? (PROD_BITS-FRAC_BITS+1)'(1) << (WORD_BITS - 1)
                             : (PROD_BITS-FRAC_BITS+1)'(WORD_MAX);

   assign add_sum = (cmd.uop.op == OP_SUB) ? {opa[OPND_BITS-1], opa} - {opb[OPND_BITS-1], opb}
                                           : {opa[OPND_BITS-1], opa} + {opb[OPND_BITS-1], opb};

   always_comb begin
      wb_in = '0;
      wb_en = 1'b0;
      wb_sat = 1'b0;
      case (cmd.uop.op)
         OP_MRND: begin
            wb_en = 1'b1;
            if (rnd_mag > rnd_limit) begin
               wb_sat = 1'b1;
               wb_in = neg_ff ? WORD_MIN : WORD_MAX;
            end else begin
               wb_in = neg_ff ? -word_type'(rnd_mag[WORD_BITS-1:0])
                              : word_type'(rnd_mag[WORD_BITS-1:0]);
            end
         end
         OP_MDIV6: begin
            wb_en = 1'b1;
            wb_in = word_type'(prod_ff[DIV6_SHIFT +: WORD_BITS-3]);
         end
         OP_ADD, OP_SUB: begin
            wb_en = 1'b1;
            if (add_sum > (OPND_BITS+1)'(WORD_MAX)) begin
               wb_sat = 1'b1;
               wb_in = WORD_MAX;
            end else if (add_sum < (OPND_BITS+1)'(WORD_MIN)) begin
               wb_sat = 1'b1;
               wb_in = WORD_MIN;
            end else begin
               wb_in = add_sum[WORD_BITS-1:0];
            end
         end
         default: wb_en = 1'b0;
      endcase
   end

   assign time_sum = {1'b0, time_ff} + {33'd0, dt_ff};
   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= A_RESET;
         b_ff <= B_RESET;
         dt_ff <= DT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_A: a_ff <= csr_wdata;
            REG_B: b_ff <= csr_wdata;
            REG_DT: dt_ff <= csr_wdata;
            default: a_ff <= a_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         time_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            sat_ff <= 1'b0;
         end else if (wb_sat) begin
            sat_ff <= 1'b1;
         end
         if (cmd.load) begin
            x_ff <= req_payload.load_x;
            y_ff <= req_payload.load_y;
            time_ff <= '0;
         end
         if (cmd.uop.op == OP_TIME) begin
            if (time_sum[TIME_BITS]) begin
               time_ff <= '1;
               sat_ff <= 1'b1;
            end else begin
               time_ff <= time_sum[TIME_BITS-1:0];
            end
         end
         // drop negative concentrations to zero
         if (wb_en && cmd.uop.dst == DST_XC) begin
            x_ff <= wb_in[WORD_BITS-1] ? '0 : wb_in[CONC_BITS-1:0];
         end
         if (wb_en && cmd.uop.dst == DST_YC) begin
            y_ff <= wb_in[WORD_BITS-1] ? '0 : wb_in[CONC_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.uop.op == OP_MUL) begin
         prod_ff <= prod_in;
         neg_ff <= neg_in;
      end
      if (wb_en) begin
         case (cmd.uop.dst)
            DST_T1: t1_ff <= wb_in;
            DST_T2: t2_ff <= wb_in;
            DST_XS: xs_ff <= wb_in;
            DST_YS: ys_ff <= wb_in;
            DST_DX: dx_ff <= wb_in;
            DST_DY: dy_ff <= wb_in;
            DST_SX: sx_ff <= wb_in;
            DST_SY: sy_ff <= wb_in;
            DST_SIX: six_ff <= wb_in;
            default: t1_ff <= t1_ff;
         endcase
      end
      // square root: two radicand bits per cycle
      if (cmd.uop.op == OP_SQSET) begin
         sum_ff <= prod_ff;
         res_ff <= '0;
         bit_ff <= PROD_BITS'(1) << (PROD_BITS - 2);
      end else if (cmd.uop.op == OP_SQACC) begin
         sum_ff <= sum_ff + prod_ff;
      end else if (cmd.sqrt_step) begin
         if (sum_ff >= trial) begin
            sum_ff <= sum_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.out_load) begin
         rsp_ff.x_out <= x_ff;
         rsp_ff.y_out <= y_ff;
         rsp_ff.time_out <= time_ff;
         rsp_ff.norm_out <= res_ff[NORM_BITS-1:0];
         rsp_ff.saturated <= sat_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
